// ----- sv/bocr_pkg.sv -----
// Shared types and constants of the farthest-next-use cache replacement block.
// Used by the top level and by its port checker; depends on nothing else.
package bocr_pkg;

    localparam int BOCR_MAX_OBJECTS = 64;

    localparam int ID_W   = 32;
    localparam int SIZE_W = 40;
    localparam int TIME_W = 48;
    localparam int CAP_W  = 48;
    localparam int CNT_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 48'd1073741824;
    localparam logic [CNT_W-1:0] EVICT_SAT = 7'd127;

    typedef struct packed {
        logic [ID_W-1:0]   object_id;
        logic [SIZE_W-1:0] object_size;
        logic [TIME_W-1:0] request_time;
        logic [TIME_W-1:0] next_use_time;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic              admitted;
        logic [CNT_W-1:0]  evicted_count;
        logic [CAP_W-1:0]  used_bytes;
    } t_rsp;

    // One table entry as it is held in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]   object_id;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] next_use;
        logic [TIME_W-1:0] last_request;
    } t_entry;

    // True if entry a is a better victim than entry b.
    function automatic logic beats(input logic [TIME_W-1:0] na, input logic [TIME_W-1:0] la,
                                   input logic [TIME_W-1:0] nb, input logic [TIME_W-1:0] lb);
        logic r;
        if (na != nb) begin
            r = (na > nb);
        end else begin
            r = (la < lb);
        end
        return r;
    endfunction

endpackage

// ----- sv/belady_optimal_cache_replacement.sv -----
// Top level of the farthest-next-use cache replacement block.
// Depends on bocr_pkg for the request, result and table entry types.
//
// Usage: a request transfer happens at a clock edge with start high and busy low.
// The block then raises busy until it has produced the result. The result is on
// o_rsp for exactly one cycle, marked by o_result_valid; the receiver cannot stall
// it, and a new request may be started in that same cycle. The user must write
// capacity_bytes through i_cfg_wr_en / i_cfg_wr_data while busy is low; not checked.
//
// Timing is set by the slot memory, which has one read port and is scanned one
// entry per cycle. A request begins with a lookup scan of the table; a hit then
// passes a decision step and a write-back step, and its result is registered
// behind the write-back. A miss adds a check step, plus one scan of the table
// per eviction.
// Reset is synchronous: it clears the slot valid bits, the resident count, the
// bytes in use, and sets the capacity to 2^30. The slot memory itself is never
// cleared; an entry is read only after it has been written.
module belady_optimal_cache_replacement
    import bocr_pkg::*;
#(
    parameter int MAX_OBJECTS = BOCR_MAX_OBJECTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    input  logic               i_cfg_wr_en,
    input  logic [CAP_W-1:0]   i_cfg_wr_data,
    output logic               o_result_valid,
    output t_rsp               o_rsp
);

    localparam int IW    = $clog2(MAX_OBJECTS);
    localparam int NW    = $clog2(MAX_OBJECTS + 1);
    localparam int TOT_W = CAP_W + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_OBJECTS - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(MAX_OBJECTS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOKUP = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_NEED   = 7'b0001000,
        S_EVSCAN = 7'b0010000,
        S_EVICT  = 7'b0100000,
        S_WRITE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    t_entry r_mem [MAX_OBJECTS];
    t_entry r_mem_q;
    logic   r_valid [MAX_OBJECTS];

    logic [CAP_W-1:0]  r_cap;
    logic [CAP_W-1:0]  r_bytes;
    logic [NW-1:0]     r_nres;
    t_req              r_req;

    logic              r_issuing;
    logic [IW-1:0]     r_idx;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;

    logic              r_found;
    logic [IW-1:0]     r_match_idx;
    logic [SIZE_W-1:0] r_match_size;
    logic              r_free_ok;
    logic [IW-1:0]     r_free_idx;

    logic              r_pending;
    logic [TOT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_evicted;

    logic              r_have;
    logic [IW-1:0]     r_victim;
    logic [TIME_W-1:0] r_bn;
    logic [TIME_W-1:0] r_bl;
    logic [SIZE_W-1:0] r_bsize;

    logic              r_out_valid;
    t_rsp              r_rsp;

    logic              rd_slot_valid;
    logic              scan_last;
    logic              too_large;
    logic              need;
    logic              cand_wins;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic [CNT_W-1:0]  evicted_inc;

    assign rd_slot_valid = r_valid[r_rd_idx];
    assign scan_last     = r_rd_vld && (r_rd_idx == LAST_IDX);
    assign too_large     = ({8'd0, r_req.object_size} > r_cap);
    assign need          = (r_total > {1'b0, r_cap}) || (r_pending && (r_nres >= FULL_CNT));
    assign cand_wins     = r_pending &&
                           (!r_have || beats(r_req.next_use_time, r_req.request_time, r_bn, r_bl));
    assign evicted_inc   = (r_evicted == EVICT_SAT) ? r_evicted : r_evicted + 1'b1;

    // The only memory write is the final write-back of a hit or an insert.
    assign mem_we    = (r_state == S_WRITE) && (r_found || r_free_ok);
    assign mem_waddr = r_found ? r_match_idx : r_free_idx;
    always_comb begin
        mem_wdata.object_id    = r_req.object_id;
        mem_wdata.size         = r_found ? r_match_size : r_req.object_size;
        mem_wdata.next_use     = r_req.next_use_time;
        mem_wdata.last_request = r_req.request_time;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[r_idx];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (scan_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_found) begin
                    n_state = S_WRITE;
                end else if (too_large) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_NEED;
                end
            end
            S_NEED: begin
                if (need) begin
                    n_state = S_EVSCAN;
                end else if (r_pending) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EVSCAN: begin
                if (scan_last) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                if (cand_wins || r_have) begin
                    n_state = S_NEED;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issuing   <= 1'b0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
            r_bytes     <= '0;
            r_nres      <= '0;
            for (int i = 0; i < MAX_OBJECTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            r_rd_vld    <= r_issuing;
            r_rd_idx    <= r_idx;

            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end

            if (r_issuing) begin
                if (r_idx == LAST_IDX) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req     <= i_req;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_pending <= 1'b0;
                        r_evicted <= '0;
                        r_idx     <= '0;
                        r_issuing <= 1'b1;
                    end
                end
                S_LOOKUP: begin
                    if (r_rd_vld) begin
                        if (rd_slot_valid && (r_mem_q.object_id == r_req.object_id) &&
                            !r_found) begin
                            r_found      <= 1'b1;
                            r_match_idx  <= r_rd_idx;
                            r_match_size <= r_mem_q.size;
                        end
                        if (!rd_slot_valid && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                    end
                end
                S_CHECK: begin
                    if (!r_found) begin
                        if (too_large) begin
                            r_out_valid         <= 1'b1;
                            r_rsp.hit           <= 1'b0;
                            r_rsp.admitted      <= 1'b0;
                            r_rsp.evicted_count <= '0;
                            r_rsp.used_bytes    <= r_bytes;
                        end else begin
                            r_pending <= 1'b1;
                            r_total   <= {1'b0, r_bytes} + TOT_W'(r_req.object_size);
                        end
                    end
                end
                S_NEED: begin
                    if (need) begin
                        r_have    <= 1'b0;
                        r_idx     <= '0;
                        r_issuing <= 1'b1;
                    end else if (!r_pending) begin
                        r_bytes             <= r_total[CAP_W-1:0];
                        r_out_valid         <= 1'b1;
                        r_rsp.hit           <= 1'b0;
                        r_rsp.admitted      <= 1'b1;
                        r_rsp.evicted_count <= r_evicted;
                        r_rsp.used_bytes    <= r_total[CAP_W-1:0];
                    end
                end
                S_EVSCAN: begin
                    if (r_rd_vld && rd_slot_valid &&
                        (!r_have ||
                         beats(r_mem_q.next_use, r_mem_q.last_request, r_bn, r_bl))) begin
                        r_have   <= 1'b1;
                        r_victim <= r_rd_idx;
                        r_bn     <= r_mem_q.next_use;
                        r_bl     <= r_mem_q.last_request;
                        r_bsize  <= r_mem_q.size;
                    end
                end
                S_EVICT: begin
                    if (cand_wins) begin
                        r_pending <= 1'b0;
                        r_total   <= r_total - TOT_W'(r_req.object_size);
                        r_evicted <= evicted_inc;
                    end else if (r_have) begin
                        r_valid[r_victim] <= 1'b0;
                        r_nres            <= r_nres - 1'b1;
                        r_total           <= r_total - TOT_W'(r_bsize);
                        r_evicted         <= evicted_inc;
                        if (!r_free_ok || (r_victim < r_free_idx)) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_victim;
                        end
                    end else begin
                        // Nothing left to evict: close the request as it stands.
                        r_bytes             <= r_total[CAP_W-1:0];
                        r_out_valid         <= 1'b1;
                        r_rsp.hit           <= 1'b0;
                        r_rsp.admitted      <= 1'b1;
                        r_rsp.evicted_count <= r_evicted;
                        r_rsp.used_bytes    <= r_total[CAP_W-1:0];
                    end
                end
                S_WRITE: begin
                    r_out_valid         <= 1'b1;
                    r_rsp.hit           <= r_found;
                    r_rsp.admitted      <= !r_found;
                    r_rsp.evicted_count <= r_evicted;
                    if (r_found) begin
                        r_rsp.used_bytes <= r_bytes;
                    end else if (r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_nres              <= r_nres + 1'b1;
                        r_bytes             <= r_total[CAP_W-1:0];
                        r_rsp.used_bytes    <= r_total[CAP_W-1:0];
                    end else begin
                        r_bytes          <= r_total[CAP_W-1:0] - CAP_W'(r_req.object_size);
                        r_rsp.used_bytes <= r_total[CAP_W-1:0] - CAP_W'(r_req.object_size);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_rsp          = r_rsp;

endmodule

// ----- sv/bocr_checker.sv -----
// Port-level checker for the farthest-next-use cache replacement block.
// Depends on bocr_pkg; attached to the top level by the bind statement below.
module bocr_checker
    import bocr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_result_valid,
    input t_rsp             o_rsp
);

    // Every result closes a request that was in flight the cycle before.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a request in flight");

    // A hit never admits or evicts anything.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_rsp.hit) |-> (!o_rsp.admitted && (o_rsp.evicted_count == '0)))
        else $error("hit reported with admission or eviction");

    // A rejected oversized miss leaves the cache untouched.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_rsp.hit && !o_rsp.admitted) |-> (o_rsp.evicted_count == '0))
        else $error("eviction on a rejected request");

    // A request transfer always makes the block busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // Results are single-cycle strobes; no two results come back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

endmodule

bind belady_optimal_cache_replacement bocr_checker u_bocr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_rsp          (o_rsp)
);
